### design/bia_pkg.sv
`timescale 1ns / 1ps
package bia_pkg;

    // Id space and derived map geometry
    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = 10;
    localparam int MAP_BYTES  = (SLOT_COUNT + 7) / 8;
    localparam int BYTE_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    localparam logic [7:0] ALL_USED = 8'hFF;
    localparam logic [7:0] ONE_BIT  = 8'h01;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the item, set the scan address
        logic read;      // read the map byte at the scan address
        logic advance;   // step the scan to the next byte
        logic commit;    // write back the byte, move the hint, record ok
        logic set_full;  // record a full result
        logic set_range; // record an out-of-range result
        logic out_load;  // move the recorded result to the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic req_range; // incoming item is a free with an id out of range
        logic func_free; // latched item is a free
        logic byte_open; // byte under check has a clear bit
        logic last_byte; // scan address is the top byte
        logic out_busy;  // output register holds an item that is not taken
    } t_sts;

    // Bits of byte k that stand for ids at or above SLOT_COUNT
    function automatic logic [7:0] pad_mask(input logic [BYTE_AW-1:0] k);
        logic [7:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if ((int'(k) * 8 + b) >= SLOT_COUNT) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

### design/bia_ctrl.sv
`timescale 1ns / 1ps
module bia_ctrl
    import bia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one item: read a byte, check it, advance or finish
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.req_range) begin
                        o_cmd.set_range = 1'b1;
                        n_state         = S_OUT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_sts.func_free || i_sts.byte_open) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_OUT;
                end else if (i_sts.last_byte) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/bia_dp.sv
`timescale 1ns / 1ps
module bia_dp
    import bia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_func,
    input  logic [SLOT_W-1:0] i_free_slot,
    input  logic              i_out_ready,
    output t_sts              o_sts,
    output logic              o_out_valid,
    output logic [SLOT_W-1:0] o_given_slot,
    output logic [1:0]        o_status
);

    // Used map: memory plus one valid bit per byte so reset frees every id
    logic [7:0]         r_mem [MAP_BYTES];
    logic               r_vld [MAP_BYTES];
    logic [7:0]         r_rd_data;
    logic               r_rd_vld;

    logic [BYTE_AW-1:0] r_hint;
    logic [BYTE_AW-1:0] r_addr;
    logic               r_func;
    logic [2:0]         r_bit;

    logic [SLOT_W-1:0]  r_res_given;
    t_status            r_res_status;
    logic               r_out_vld;
    logic [SLOT_W-1:0]  r_out_given;
    t_status            r_out_status;

    logic [7:0]         w_raw;
    logic [7:0]         w_seen;
    logic [2:0]         w_low;
    logic [7:0]         w_wdata;
    logic               w_range;

    // Check the incoming id against the id space
    assign w_range = i_func && (32'(i_free_slot) >= 32'(SLOT_COUNT));

    // Byte as the scan sees it: unwritten reads as free, padding as used
    assign w_raw  = r_rd_vld ? r_rd_data : 8'h00;
    assign w_seen = w_raw | pad_mask(r_addr);

    // Find the lowest clear bit
    always_comb begin
        w_low = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (!w_seen[b]) begin
                w_low = 3'(b);
            end
        end
    end

    assign w_wdata = r_func ? (w_raw & ~(ONE_BIT << r_bit))
                            : (w_raw | (ONE_BIT << w_low));

    assign o_sts.req_range = w_range;
    assign o_sts.func_free = r_func;
    assign o_sts.byte_open = (w_seen != ALL_USED);
    assign o_sts.last_byte = (r_addr == BYTE_AW'(MAP_BYTES - 1));
    assign o_sts.out_busy  = r_out_vld && !i_out_ready;

    // Latch the item and step the scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_bit  <= i_free_slot[2:0];
            r_addr <= i_func ? BYTE_AW'(i_free_slot >> 3) : r_hint;
        end else if (i_cmd.advance) begin
            r_addr <= r_addr + BYTE_AW'(1);
        end
    end

    // Read and write the map
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_addr];
            r_rd_vld  <= r_vld[r_addr];
        end
        if (i_cmd.commit) begin
            r_mem[r_addr] <= w_wdata;
        end
    end

    // Mark written bytes valid; reset drops them all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAP_BYTES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    // Move the hint to the byte just touched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint <= '0;
        end else if (i_cmd.commit) begin
            r_hint <= r_addr;
        end
    end

    // Record the result of the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_range || i_cmd.set_full) begin
            r_res_given  <= '0;
            r_res_status <= i_cmd.set_range ? ST_RANGE : ST_FULL;
        end else if (i_cmd.commit) begin
            r_res_given  <= r_func ? '0 : SLOT_W'({r_addr, w_low});
            r_res_status <= ST_OK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_given  <= r_res_given;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_given_slot = r_out_given;
    assign o_status     = r_out_status;

    // An allocate only commits into a byte that has a clear bit
    a_alloc_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && !r_func |-> w_seen != ALL_USED)
        else $error("allocate committed into a full byte");

    // The output register is never overwritten while it waits
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_vld && !i_out_ready))
        else $error("result overwritten before it was taken");

    // The hint follows the committed byte
    a_hint_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_hint == $past(r_addr))
        else $error("hint did not move to the committed byte");

    // A failed item reports no id
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_out_status == ST_FULL || r_out_status == ST_RANGE)
        |-> o_given_slot == '0)
        else $error("failed item reports a nonzero id");

endmodule

### design/bitmap_id_allocator_with_hint.sv
`timescale 1ns / 1ps
// Steps: a free is accepted, reads its map byte and clears its bit; a free out of range records
//   a range result at once; an allocate reads and checks n map bytes (1..128) from the hint on.
// Flow: one item at a time; the next item is accepted the cycle after the result enters the output
//   register, held back while it has an untaken result; the scan reads one map byte at a time.
// Reset: synchronous, active low; per-byte valid bits free every id at once, hint at zero.
module bitmap_id_allocator_with_hint
    import bia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [SLOT_W-1:0] i_free_slot,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SLOT_W-1:0] o_given_slot,
    output logic [1:0]        o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    bia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    bia_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_func),
        .i_free_slot  (i_free_slot),
        .i_out_ready  (i_out_ready),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .o_given_slot (o_given_slot),
        .o_status     (o_status)
    );

endmodule
